[rtl/core/cqsd_pkg.sv]
// cqsd_pkg: shared types and constants for the circular queue with search and drop
// used by cqsd_cell and circular_queue_search_drop; no dependencies
package cqsd_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 6;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [DATA_W-1:0] push_data;
    } t_cell_ctrl;

endpackage

[rtl/core/cqsd_cell.sv]
// cqsd_cell: one storage slot of the queue chain, head at index zero
// takes its neighbor's word on a pop, loads the pushed word when it is the fill position
// depends on cqsd_pkg
module cqsd_cell
    import cqsd_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 6
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_nbr_data,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic              w_is_tail;

    assign w_is_tail = (i_count == CNT_W'(CELL_IDX));
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_data <= i_nbr_data;
        end else if (i_ctrl.push && w_is_tail) begin
            r_data <= i_ctrl.push_data;
        end
    end

endmodule

[rtl/core/circular_queue_search_drop.sv]
// circular_queue_search_drop: queue of signed words with add, remove and search-and-drop
// built as a chain of cqsd_cell slots with the oldest entry in cell zero
// depends on cqsd_pkg and cqsd_cell
//
// usage: drive i_command and i_value and raise start; the request is taken at a rising
// edge where start is high and busy is low. each request gives exactly one result on
// o_read_value, o_found, o_status and o_occupancy, valid for the single cycle o_strobe
// is high. the receiver cannot stall, so a result must be taken in that cycle.
// add, remove, unused codes and a search of an empty queue give their result in the cycle
// after the request and leave busy low, so one request per cycle is taken.
// a search of a non-empty queue pops one entry per cycle from the head of the chain,
// comparing it with the key; it finishes at the first match or when the queue runs out,
// and busy stays high until its result is shown.
// the pop rate of one entry per cycle is set by the chain shifting by one cell.
// reset: synchronous, active low; the queue comes out empty and busy is low; the
// slot contents are not cleared.
module circular_queue_search_drop
    import cqsd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_strobe,
    output logic signed [DATA_W-1:0]   o_read_value,
    output logic                       o_found,
    output logic [STATUS_W-1:0]        o_status,
    output logic [OCC_W-1:0]           o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [DATA_W-1:0]    r_key;
    logic                 r_strobe;
    logic [DATA_W-1:0]    r_read_value;
    logic                 r_found;
    t_status              r_status;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_head_match;
    t_cmd                 w_cmd;
    t_cell_ctrl           w_ctrl;
    logic [CNT_W+OCC_W-1:0] w_occ_wide;
    logic [DATA_W-1:0]    cell_data [CAPACITY];

    assign w_accept     = start && (r_state == S_IDLE);
    assign w_full       = (r_count == CNT_W'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_cmd        = t_cmd'(i_command);
    assign w_head_match = (cell_data[0] == r_key);

    always_comb begin
        w_ctrl.push      = w_accept && (w_cmd == CMD_ADD) && !w_full;
        w_ctrl.pop       = (w_accept && (w_cmd == CMD_REMOVE) && !w_empty)
                           || (r_state == S_SEARCH);
        w_ctrl.push_data = i_value;
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_W-1:0] w_nbr;
        if (gi == CAPACITY - 1) begin : g_last
            assign w_nbr = cell_data[gi];
        end else begin : g_mid
            assign w_nbr = cell_data[gi+1];
        end
        cqsd_cell #(
            .CELL_IDX (gi),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_nbr_data (w_nbr),
            .o_data     (cell_data[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_read_value <= '0;
                        r_found      <= 1'b0;
                        r_status     <= STAT_OK;
                        case (w_cmd)
                            CMD_ADD: begin
                                r_strobe <= 1'b1;
                                if (w_full) begin
                                    r_status <= STAT_FULL;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            CMD_REMOVE: begin
                                r_strobe <= 1'b1;
                                if (w_empty) begin
                                    r_status <= STAT_EMPTY;
                                end else begin
                                    r_read_value <= cell_data[0];
                                    r_count      <= r_count - 1'b1;
                                end
                            end
                            CMD_SEARCH: begin
                                r_key <= i_value;
                                if (w_empty) begin
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: begin
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    r_count <= r_count - 1'b1;
                    if (w_head_match || (r_count == CNT_W'(1))) begin
                        r_state      <= S_IDLE;
                        r_strobe     <= 1'b1;
                        r_found      <= w_head_match;
                        r_read_value <= w_head_match ? cell_data[0] : '0;
                        r_status     <= STAT_OK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_occ_wide   = {{OCC_W{1'b0}}, r_count};
    assign busy         = (r_state == S_SEARCH);
    assign o_strobe     = r_strobe;
    assign o_read_value = r_read_value;
    assign o_found      = r_found;
    assign o_status     = r_status;
    assign o_occupancy  = w_occ_wide[OCC_W-1:0];

    // a search in progress always has an entry left to pop
    a_search_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_count != '0))
        else $error("search running on an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_ADD) && !w_full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted add did not grow the queue");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status != STAT_OK)) |-> (!r_found && (r_read_value == '0)))
        else $error("refused request reported data");

    a_search_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && w_head_match) |=> (r_strobe && r_found && !busy))
        else $error("search match not reported");

endmodule

[dv/tb_circular_queue_search_drop.sv]
// tb_circular_queue_search_drop: self-checking bench for the circular queue with search and drop
// a shadow queue predicts every command outcome, and a monitor checks each strobed result
// depends on cqsd_pkg and circular_queue_search_drop
module tb_circular_queue_search_drop;
    import cqsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = CAPACITY_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
    } t_queue_outcome;

    class queue_scoreboard;
        logic signed [DATA_W-1:0] shadow_entries[$];
        t_queue_outcome           pending_outcomes[$];
        int errors;
        int checked;
        int full_refusals;
        int empty_removes;
        int search_hits;
        int search_misses;

        function void note_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
            t_queue_outcome res;
            logic signed [DATA_W-1:0] popped;
            res.read_value = '0;
            res.found      = 1'b0;
            res.status     = STAT_OK;
            case (cmd)
                CMD_ADD: begin
                    if (shadow_entries.size() >= DEPTH) begin
                        res.status = STAT_FULL;
                        full_refusals++;
                    end else begin
                        shadow_entries.push_back(val);
                    end
                end
                CMD_REMOVE: begin
                    if (shadow_entries.size() == 0) begin
                        res.status = STAT_EMPTY;
                        empty_removes++;
                    end else begin
                        res.read_value = shadow_entries.pop_front();
                    end
                end
                CMD_SEARCH: begin
                    while (shadow_entries.size() > 0 && !res.found) begin
                        popped = shadow_entries.pop_front();
                        if (popped == val) begin
                            res.read_value = popped;
                            res.found      = 1'b1;
                        end
                    end
                    if (res.found) search_hits++;
                    else search_misses++;
                end
                default: begin
                end
            endcase
            res.occupancy = OCC_W'(shadow_entries.size());
            pending_outcomes.push_back(res);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_result(t_queue_outcome act);
            t_queue_outcome exp_res;
            if (pending_outcomes.size() == 0) begin
                report("result strobed with no request outstanding");
                return;
            end
            exp_res = pending_outcomes.pop_front();
            checked++;
            if (act.read_value !== exp_res.read_value)
                report($sformatf("read_value expected %h got %h",
                                 exp_res.read_value, act.read_value));
            if (act.found !== exp_res.found)
                report($sformatf("found expected %0d got %0d", exp_res.found, act.found));
            if (act.status !== exp_res.status)
                report($sformatf("status expected %0d got %0d", exp_res.status, act.status));
            if (act.occupancy !== exp_res.occupancy)
                report($sformatf("occupancy expected %0d got %0d",
                                 exp_res.occupancy, act.occupancy));
        endfunction

        function int held_count();
            return shadow_entries.size();
        endfunction

        function logic signed [DATA_W-1:0] pick_held();
            return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         i_command;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_read_value;
    logic                     o_found;
    logic [STATUS_W-1:0]      o_status;
    logic [OCC_W-1:0]         o_occupancy;

    queue_scoreboard sb;
    int idle_pct;

    circular_queue_search_drop #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_read_value(o_read_value),
        .o_found     (o_found),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        t_queue_outcome act;
        if (i_rst_n && o_strobe) begin
            act.read_value = o_read_value;
            act.found      = o_found;
            act.status     = o_status;
            act.occupancy  = o_occupancy;
            sb.check_result(act);
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            i_command <= CMD_W'($urandom);
            i_value   <= $urandom;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        @(posedge i_clk);
        sb.note_request(cmd, val);
    endtask

    function automatic logic signed [DATA_W-1:0] random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return $urandom_range(0, 15);
        if (pick < 75) return -$signed(32'($urandom_range(1, 8)));
        return $urandom;
    endfunction

    task automatic run_random(int count);
        int pick;
        int add_pct;
        logic [CMD_W-1:0] cmd;
        logic signed [DATA_W-1:0] val;
        for (int i = 0; i < count; i++) begin
            // alternate filling, draining and mixed stretches so both ends are reached
            case ((i / 40) % 3)
                0: add_pct = 90;
                1: add_pct = 20;
                default: add_pct = 50;
            endcase
            pick = $urandom_range(99);
            if (pick < 3) cmd = CMD_UNUSED;
            else if (pick < add_pct) cmd = CMD_ADD;
            else if ($urandom_range(99) < 55) cmd = CMD_REMOVE;
            else cmd = CMD_SEARCH;
            if (cmd == CMD_SEARCH && sb.held_count() > 0 && $urandom_range(99) < 60)
                val = sb.pick_held();
            else
                val = random_word();
            send_request(cmd, val);
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_command = '0;
        i_value   = '0;
        idle_pct  = 0;
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        idle_pct = 36;
        send_request(CMD_REMOVE, 0);
        send_request(CMD_SEARCH, 5);
        send_request(CMD_UNUSED, 32'h7FFF_FFFF);
        send_request(CMD_ADD, 32'h7FFF_FFFF);
        send_request(CMD_ADD, 32'h8000_0000);
        send_request(CMD_ADD, -1);
        send_request(CMD_ADD, 0);
        send_request(CMD_ADD, 32'h5555_5555);
        send_request(CMD_UNUSED, 0);
        send_request(CMD_SEARCH, -1);
        send_request(CMD_REMOVE, 0);
        send_request(CMD_REMOVE, 0);
        send_request(CMD_REMOVE, 0);
        send_request(CMD_ADD, 1);
        send_request(CMD_ADD, 2);
        send_request(CMD_ADD, 3);
        send_request(CMD_SEARCH, 1);
        send_request(CMD_SEARCH, 3);
        send_request(CMD_ADD, 7);
        send_request(CMD_ADD, 8);
        send_request(CMD_SEARCH, 99);
        send_request(CMD_ADD, 32'hAAAA_AAAA);
        send_request(CMD_SEARCH, 32'hAAAA_AAAA);

        idle_pct = 36;
        run_random(150);
        idle_pct = 63;
        run_random(150);
        idle_pct = 0;
        run_random(150);

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("checked %0d results: %0d adds refused full, %0d removes on empty",
                 sb.checked, sb.full_refusals, sb.empty_removes);
        $display("searches: %0d found the key, %0d ran the queue dry; %0d mismatches",
                 sb.search_hits, sb.search_misses, sb.errors);
        if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
